### design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is applied
`define NFHFE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define NFHFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/nfhfe_pkg.sv
// ---------------------------------------------------------------------------
// nfhfe_pkg
// Types, constants and helpers for the host frame encoder.
// ---------------------------------------------------------------------------
package nfhfe_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [7:0] PREAMBLE_RST   = 8'h00;
	localparam logic [7:0] START1_RST     = 8'h00;
	localparam logic [7:0] START2_RST     = 8'hFF;
	localparam logic [7:0] POSTAMBLE_RST  = 8'h00;
	localparam logic [7:0] TFI_H2D_RST    = 8'hD4;
	localparam logic [7:0] TFI_D2H_RST    = 8'hD5;
	localparam logic [7:0] WR_PREFIX_RST  = 8'h01;
	localparam logic [7:0] LEN_INVALID_LO = 8'h00;
	localparam logic [7:0] LEN_INVALID_HI = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREAMBLE  = 3'd0,
		REG_START1    = 3'd1,
		REG_START2    = 3'd2,
		REG_POSTAMBLE = 3'd3,
		REG_TFI_H2D   = 3'd4,
		REG_TFI_D2H   = 3'd5,
		REG_WR_PREFIX = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] prefix_byte;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
		logic       first_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       last_of_frame;
	} out_item_t;

	typedef struct packed {
		logic [7:0] preamble_byte;
		logic [7:0] start_code_first;
		logic [7:0] start_code_second;
		logic [7:0] postamble_byte;
		logic [7:0] tfi_host_to_device;
		logic [7:0] tfi_device_to_host;
		logic [7:0] write_prefix;
	} cfg_t;

	// one payload byte, classified, with everything the back end needs
	typedef struct packed {
		logic       hdr;
		logic       tail;
		logic [7:0] prefix;
		logic [7:0] len_byte;
		logic [7:0] lcs;
		logic [7:0] tfi;
		logic [7:0] data;
		logic [7:0] dcs;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_PREAMBLE,
		ST_START1,
		ST_START2,
		ST_LEN,
		ST_LCS,
		ST_TFI,
		ST_DATA,
		ST_DCS,
		ST_POST
	} step_t;

	function automatic logic [7:0] bit_rev(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

endpackage

### design/nfhfe_front.sv
// ---------------------------------------------------------------------------
// nfhfe_front
// Accepts payload bytes, tracks the open frame and issues byte commands.
// ---------------------------------------------------------------------------
module nfhfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  nfhfe_pkg::in_item_t item,
	input  nfhfe_pkg::cfg_t     cfg,
	output logic                cmd_push,
	output nfhfe_pkg::cmd_t     cmd
);

	logic [7:0] sum_q;
	logic [7:0] remain_q;
	logic       open_q;

	logic       len_bad;
	logic [7:0] base_sum;
	logic [7:0] base_rem;
	logic [7:0] sum_new;
	logic [7:0] rem_new;
	logic [7:0] tfi;
	logic [7:0] len_byte;

	always_comb begin
		len_bad  = (item.payload_length == nfhfe_pkg::LEN_INVALID_LO) ||
			(item.payload_length == nfhfe_pkg::LEN_INVALID_HI);
		tfi      = (item.prefix_byte == cfg.write_prefix) ?
			cfg.tfi_host_to_device : cfg.tfi_device_to_host;
		len_byte = item.payload_length + 8'd1;
		base_sum = item.first_of_frame ? tfi : sum_q;
		base_rem = item.first_of_frame ? item.payload_length : remain_q;
		sum_new  = base_sum + item.payload_byte;
		rem_new  = base_rem - 8'd1;

		cmd_push = accept && (item.first_of_frame ? !len_bad : open_q);

		cmd.hdr      = item.first_of_frame;
		cmd.tail     = (rem_new == 8'd0);
		cmd.prefix   = item.prefix_byte;
		cmd.len_byte = len_byte;
		cmd.lcs      = ~len_byte + 8'd1;
		cmd.tfi      = tfi;
		cmd.data     = item.payload_byte;
		cmd.dcs      = ~sum_new + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			remain_q <= '0;
			open_q   <= 1'b0;
		end else if (accept) begin
			if (item.first_of_frame && len_bad) begin
				// bad length closes any open frame silently
				sum_q    <= '0;
				remain_q <= '0;
				open_q   <= 1'b0;
			end else if (cmd_push) begin
				if (cmd.tail) begin
					sum_q    <= '0;
					remain_q <= '0;
					open_q   <= 1'b0;
				end else begin
					sum_q    <= sum_new;
					remain_q <= rem_new;
					open_q   <= 1'b1;
				end
			end
		end
	end

endmodule

### design/nfhfe_queue.sv
// ---------------------------------------------------------------------------
// nfhfe_queue
// Small command queue between the front and back ends.
// ---------------------------------------------------------------------------
module nfhfe_queue #(
	parameter int unsigned DEPTH = nfhfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  nfhfe_pkg::cmd_t      wr_data,
	input  logic                 rd_en,
	output nfhfe_pkg::cmd_t      rd_data,
	output nfhfe_pkg::q_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	nfhfe_pkg::cmd_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		status.full  = (count_q == CNT_W'(DEPTH));
		status.empty = (count_q == '0);
		do_wr        = wr_en && !status.full;
		do_rd        = rd_en && !status.empty;
		rd_data      = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/nfhfe_back.sv
// ---------------------------------------------------------------------------
// nfhfe_back
// Expands each command into result register bytes, one per cycle unless stalled.
// ---------------------------------------------------------------------------
module nfhfe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nfhfe_pkg::cmd_t      head,
	input  logic                 head_valid,
	input  nfhfe_pkg::cfg_t      cfg,
	input  logic                 pop,
	output logic                 head_done,
	output logic                 empty,
	output nfhfe_pkg::out_item_t result
);

	nfhfe_pkg::step_t     step_q;
	nfhfe_pkg::step_t     step_d;
	nfhfe_pkg::step_t     cur;
	nfhfe_pkg::step_t     succ;
	nfhfe_pkg::out_item_t result_q;
	logic                 valid_q;
	logic                 load;
	logic                 last;
	logic [7:0]           byte_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= nfhfe_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		if (step_q == nfhfe_pkg::ST_IDLE) begin
			cur = head.hdr ? nfhfe_pkg::ST_PREFIX : nfhfe_pkg::ST_DATA;
		end else begin
			cur = step_q;
		end

		load = head_valid && (!valid_q || pop);
		last = ((cur == nfhfe_pkg::ST_DATA) && !head.tail) || (cur == nfhfe_pkg::ST_POST);

		unique case (cur)
			nfhfe_pkg::ST_PREFIX: begin
				byte_sel = head.prefix;
				succ     = nfhfe_pkg::ST_PREAMBLE;
			end
			nfhfe_pkg::ST_PREAMBLE: begin
				byte_sel = cfg.preamble_byte;
				succ     = nfhfe_pkg::ST_START1;
			end
			nfhfe_pkg::ST_START1: begin
				byte_sel = cfg.start_code_first;
				succ     = nfhfe_pkg::ST_START2;
			end
			nfhfe_pkg::ST_START2: begin
				byte_sel = cfg.start_code_second;
				succ     = nfhfe_pkg::ST_LEN;
			end
			nfhfe_pkg::ST_LEN: begin
				byte_sel = head.len_byte;
				succ     = nfhfe_pkg::ST_LCS;
			end
			nfhfe_pkg::ST_LCS: begin
				byte_sel = head.lcs;
				succ     = nfhfe_pkg::ST_TFI;
			end
			nfhfe_pkg::ST_TFI: begin
				byte_sel = head.tfi;
				succ     = nfhfe_pkg::ST_DATA;
			end
			nfhfe_pkg::ST_DATA: begin
				byte_sel = head.data;
				succ     = nfhfe_pkg::ST_DCS;
			end
			nfhfe_pkg::ST_DCS: begin
				byte_sel = head.dcs;
				succ     = nfhfe_pkg::ST_POST;
			end
			nfhfe_pkg::ST_POST: begin
				byte_sel = cfg.postamble_byte;
				succ     = nfhfe_pkg::ST_IDLE;
			end
			default: begin
				byte_sel = head.data;
				succ     = nfhfe_pkg::ST_IDLE;
			end
		endcase

		step_d    = step_q;
		head_done = 1'b0;
		if (load) begin
			if (last) begin
				step_d    = nfhfe_pkg::ST_IDLE;
				head_done = 1'b1;
			end else begin
				step_d = succ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.line_byte     <= nfhfe_pkg::bit_rev(byte_sel);
			result_q.last_of_frame <= (cur == nfhfe_pkg::ST_POST);
		end
	end

	assign empty  = !valid_q;
	assign result = result_q;

endmodule

### design/nfc_host_frame_encoder_core.sv
// ---------------------------------------------------------------------------
// nfc_host_frame_encoder_core
// Information frame encoder: header, payload pass-through, checksum, postamble.
// ---------------------------------------------------------------------------
//  channel   handshake           payload
//  input     push / full         item   (prefix, length, payload byte, first flag)
//  result    pop / empty         result (bit-reversed line byte, last flag)
//  config    cfg_we              cfg_index, cfg_data
//
//  one result byte leaves per cycle while pop takes it; a payload byte is taken
//  per cycle while the command queue (QUEUE_DEPTH entries) has room.
//  a first byte adds prefix, preamble, start codes, length, LCS and TFI before
//  its data and a closing byte adds DCS and postamble, so input sees full while
//  the back end works through header and trailer bytes. reset clears the queue,
//  frame state and result valid flag and loads the register defaults.
// ---------------------------------------------------------------------------
module nfc_host_frame_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = nfhfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  nfhfe_pkg::in_item_t                 item,
	output logic                                empty,
	input  logic                                pop,
	output nfhfe_pkg::out_item_t                result,
	input  logic                                cfg_we,
	input  logic [nfhfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                          cfg_data
);

	nfhfe_pkg::cfg_t      cfg_q;
	nfhfe_pkg::cmd_t      cmd;
	nfhfe_pkg::cmd_t      head;
	nfhfe_pkg::q_status_t q_status;
	logic                 cmd_push;
	logic                 head_done;
	logic                 accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_byte      <= nfhfe_pkg::PREAMBLE_RST;
			cfg_q.start_code_first   <= nfhfe_pkg::START1_RST;
			cfg_q.start_code_second  <= nfhfe_pkg::START2_RST;
			cfg_q.postamble_byte     <= nfhfe_pkg::POSTAMBLE_RST;
			cfg_q.tfi_host_to_device <= nfhfe_pkg::TFI_H2D_RST;
			cfg_q.tfi_device_to_host <= nfhfe_pkg::TFI_D2H_RST;
			cfg_q.write_prefix       <= nfhfe_pkg::WR_PREFIX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nfhfe_pkg::REG_PREAMBLE:  cfg_q.preamble_byte      <= cfg_data;
				nfhfe_pkg::REG_START1:    cfg_q.start_code_first   <= cfg_data;
				nfhfe_pkg::REG_START2:    cfg_q.start_code_second  <= cfg_data;
				nfhfe_pkg::REG_POSTAMBLE: cfg_q.postamble_byte     <= cfg_data;
				nfhfe_pkg::REG_TFI_H2D:   cfg_q.tfi_host_to_device <= cfg_data;
				nfhfe_pkg::REG_TFI_D2H:   cfg_q.tfi_device_to_host <= cfg_data;
				nfhfe_pkg::REG_WR_PREFIX: cfg_q.write_prefix       <= cfg_data;
				default:                  cfg_q                    <= cfg_q;
			endcase
		end
	end

	assign full   = q_status.full;
	assign accept = push && !q_status.full;

	nfhfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg_q),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	nfhfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd),
		.rd_en   (head_done),
		.rd_data (head),
		.status  (q_status)
	);

	nfhfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_status.empty),
		.cfg        (cfg_q),
		.pop        (pop),
		.head_done  (head_done),
		.empty      (empty),
		.result     (result)
	);

endmodule

### design/nfhfe_checker.sv
// ---------------------------------------------------------------------------
// nfhfe_checker
// Port-level checks on the frame encoder, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nfhfe_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input nfhfe_pkg::in_item_t  item,
	input logic                 empty,
	input logic                 pop,
	input nfhfe_pkg::out_item_t result
);

	// queue and result register are clear once a reset edge has been seen
	`NFHFE_ASSERT_ALWAYS(a_reset_clear, clk, !arst_n |=> (empty && !full), "not clear in reset")

	// a waiting result holds until it is taken
	`NFHFE_ASSERT(a_result_hold, clk, arst_n,
		(!empty && !pop) |=> (!empty && $stable(result)), "result changed while stalled")

	// a full queue with the result register idle moves work into it
	`NFHFE_ASSERT(a_full_drains, clk, arst_n, (full && empty) |=> !empty,
		"queue full with result register idle")

	// a valid frame start with the result register idle shows a result, via the queue and result register
	`NFHFE_ASSERT(a_start_result, clk, arst_n,
		(push && !full && item.first_of_frame && empty &&
		item.payload_length != nfhfe_pkg::LEN_INVALID_LO &&
		item.payload_length != nfhfe_pkg::LEN_INVALID_HI) |=> ##1 !empty,
		"frame start gave no result")

endmodule

bind nfc_host_frame_encoder_core nfhfe_checker u_nfhfe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
